>>> design/srt_pkg.sv
`default_nettype none

package srt_pkg;

    // Table size and field widths.
    localparam int CAPACITY  = 64;
    localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int KEY_W     = 31;
    localparam int DATA_W    = 64;
    localparam int OUT_CNT_W = 7;
    localparam int REC_W     = KEY_W + DATA_W;

    // Request codes carried on i_req_type.
    typedef enum logic [1:0] {
        REQ_INSERT    = 2'd0,
        REQ_DEL_FIRST = 2'd1,
        REQ_DEL_ALL   = 2'd2
    } t_req;

    // Status codes returned on o_status.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_INS_LAST,
        S_SCAN,
        S_RESP
    } t_state;

endpackage

`default_nettype wire

>>> design/sorted_record_table_top.sv
// Channel   | Ports                                              | Handshake
// ----------+----------------------------------------------------+------------------------
// request   | i_req_type, i_record_key, i_record_data            | start high, busy low
// result    | o_status, o_found_key, o_found_data,               | o_done high, one cycle
//           | o_removed_count, o_entry_count                     |
//
// Records live in one memory with a registered read port; a small sequencer walks it
// one entry per cycle, reading one entry ahead of the entry it writes.
// An insert moves each entry not below the new key up one place, from the top down, then
// writes the new record; an insert into an empty or full table skips the shift.
// Either delete scans every entry held; an empty table and the unused code skip the scan.
// busy stays high through the o_done cycle, so the next request is taken in the following
// cycle at the earliest. The receiver cannot stall.
// Synchronous active-low reset empties the table; no memory clearing pass is needed.
`default_nettype none

module sorted_record_table_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [1:0]                          i_req_type,
    input  wire logic [srt_pkg::KEY_W-1:0]           i_record_key,
    input  wire logic [srt_pkg::DATA_W-1:0]          i_record_data,
    output logic                                     o_done,
    output logic [1:0]                               o_status,
    output logic [srt_pkg::KEY_W-1:0]                o_found_key,
    output logic [srt_pkg::DATA_W-1:0]               o_found_data,
    output logic [srt_pkg::OUT_CNT_W-1:0]            o_removed_count,
    output logic [srt_pkg::OUT_CNT_W-1:0]            o_entry_count
);

    srt_pkg::t_state                  r_state, n_state;
    srt_pkg::t_req                    r_req, n_req;
    logic [srt_pkg::KEY_W-1:0]        r_key, n_key;
    logic [srt_pkg::DATA_W-1:0]       r_data, n_data;
    logic [srt_pkg::CNT_W-1:0]        r_fill, n_fill;
    logic [srt_pkg::IDX_W-1:0]        r_ridx, n_ridx;
    logic [srt_pkg::IDX_W-1:0]        r_wp, n_wp;
    logic [srt_pkg::CNT_W-1:0]        r_removed, n_removed;
    srt_pkg::t_status                 r_status, n_status;
    logic [srt_pkg::KEY_W-1:0]        r_fkey, n_fkey;
    logic [srt_pkg::DATA_W-1:0]       r_fdata, n_fdata;

    logic [srt_pkg::REC_W-1:0]        r_mem [srt_pkg::CAPACITY];
    logic [srt_pkg::REC_W-1:0]        r_rdata;
    logic                             mem_we;
    logic [srt_pkg::IDX_W-1:0]        mem_waddr;
    logic [srt_pkg::REC_W-1:0]        mem_wdata;
    logic                             mem_re;
    logic [srt_pkg::IDX_W-1:0]        mem_raddr;

    logic                             accept;
    logic                             tbl_full;
    logic                             tbl_empty;
    logic [srt_pkg::KEY_W-1:0]        rd_key;
    logic                             ins_shift;
    logic                             ins_at_bottom;
    logic                             scan_match;
    logic                             scan_last;
    logic [srt_pkg::CNT_W-1:0]        removed_inc;

    // Shared conditions used by the sequencer and the datapath.
    assign accept        = start && (r_state == srt_pkg::S_IDLE);
    assign tbl_full      = (r_fill >= srt_pkg::CNT_W'(srt_pkg::CAPACITY));
    assign tbl_empty     = (r_fill == '0);
    assign rd_key        = r_rdata[srt_pkg::REC_W-1 -: srt_pkg::KEY_W];
    assign ins_shift     = (rd_key >= r_key);
    assign ins_at_bottom = (r_ridx == '0);
    assign scan_match    = (rd_key == r_key) &&
                           ((r_req == srt_pkg::REQ_DEL_ALL) || (r_removed == '0));
    assign scan_last     = ((srt_pkg::CNT_W'(r_ridx) + srt_pkg::CNT_W'(1)) == r_fill);
    assign removed_inc   = r_removed + srt_pkg::CNT_W'(1);

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            srt_pkg::S_IDLE: begin
                if (accept) begin
                    case (srt_pkg::t_req'(i_req_type))
                        srt_pkg::REQ_INSERT: begin
                            if (tbl_full || tbl_empty) begin
                                n_state = srt_pkg::S_RESP;
                            end else begin
                                n_state = srt_pkg::S_INS;
                            end
                        end
                        srt_pkg::REQ_DEL_FIRST,
                        srt_pkg::REQ_DEL_ALL: begin
                            n_state = tbl_empty ? srt_pkg::S_RESP : srt_pkg::S_SCAN;
                        end
                        default: n_state = srt_pkg::S_RESP;
                    endcase
                end
            end
            srt_pkg::S_INS: begin
                if (!ins_shift) begin
                    n_state = srt_pkg::S_RESP;
                end else if (ins_at_bottom) begin
                    n_state = srt_pkg::S_INS_LAST;
                end
            end
            srt_pkg::S_INS_LAST: n_state = srt_pkg::S_RESP;
            srt_pkg::S_SCAN: begin
                if (scan_last) begin
                    n_state = srt_pkg::S_RESP;
                end
            end
            srt_pkg::S_RESP: n_state = srt_pkg::S_IDLE;
            default:         n_state = srt_pkg::S_IDLE;
        endcase
    end

    // Datapath and memory control for each state.
    always_comb begin
        n_req     = r_req;
        n_key     = r_key;
        n_data    = r_data;
        n_fill    = r_fill;
        n_ridx    = r_ridx;
        n_wp      = r_wp;
        n_removed = r_removed;
        n_status  = r_status;
        n_fkey    = r_fkey;
        n_fdata   = r_fdata;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = {r_key, r_data};
        mem_re    = 1'b0;
        mem_raddr = '0;
        case (r_state)
            srt_pkg::S_IDLE: begin
                if (accept) begin
                    n_req     = srt_pkg::t_req'(i_req_type);
                    n_key     = i_record_key;
                    n_data    = i_record_data;
                    n_wp      = '0;
                    n_removed = '0;
                    n_status  = srt_pkg::ST_OK;
                    n_fkey    = '0;
                    n_fdata   = '0;
                    case (srt_pkg::t_req'(i_req_type))
                        srt_pkg::REQ_INSERT: begin
                            if (tbl_full) begin
                                n_status = srt_pkg::ST_FULL;
                            end else if (tbl_empty) begin
                                // First record goes straight into entry zero.
                                mem_we    = 1'b1;
                                mem_waddr = '0;
                                mem_wdata = {i_record_key, i_record_data};
                                n_fill    = srt_pkg::CNT_W'(1);
                            end else begin
                                // Start the top-down shift at the last entry.
                                mem_re    = 1'b1;
                                mem_raddr = srt_pkg::IDX_W'(r_fill - srt_pkg::CNT_W'(1));
                                n_ridx    = srt_pkg::IDX_W'(r_fill - srt_pkg::CNT_W'(1));
                            end
                        end
                        srt_pkg::REQ_DEL_FIRST,
                        srt_pkg::REQ_DEL_ALL: begin
                            if (tbl_empty) begin
                                if (srt_pkg::t_req'(i_req_type) == srt_pkg::REQ_DEL_FIRST) begin
                                    n_status = srt_pkg::ST_NOT_FOUND;
                                end
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = '0;
                                n_ridx    = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            srt_pkg::S_INS: begin
                // Entries not below the new key move up one place.
                mem_we    = 1'b1;
                mem_waddr = r_ridx + srt_pkg::IDX_W'(1);
                if (ins_shift) begin
                    mem_wdata = r_rdata;
                    if (!ins_at_bottom) begin
                        mem_re    = 1'b1;
                        mem_raddr = r_ridx - srt_pkg::IDX_W'(1);
                        n_ridx    = r_ridx - srt_pkg::IDX_W'(1);
                    end
                end else begin
                    mem_wdata = {r_key, r_data};
                    n_fill    = r_fill + srt_pkg::CNT_W'(1);
                end
            end
            srt_pkg::S_INS_LAST: begin
                // Every entry moved, so the new record takes entry zero.
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = {r_key, r_data};
                n_fill    = r_fill + srt_pkg::CNT_W'(1);
            end
            srt_pkg::S_SCAN: begin
                // Compact the table: kept entries are written back at the write pointer.
                if (scan_match) begin
                    n_removed = removed_inc;
                    if (r_req == srt_pkg::REQ_DEL_FIRST) begin
                        n_fkey  = rd_key;
                        n_fdata = r_rdata[srt_pkg::DATA_W-1:0];
                    end
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_wp;
                    mem_wdata = r_rdata;
                    n_wp      = r_wp + srt_pkg::IDX_W'(1);
                end
                if (scan_last) begin
                    n_fill = r_fill - (scan_match ? removed_inc : r_removed);
                    if ((r_req == srt_pkg::REQ_DEL_FIRST) && !scan_match &&
                        (r_removed == '0)) begin
                        n_status = srt_pkg::ST_NOT_FOUND;
                    end
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_ridx + srt_pkg::IDX_W'(1);
                    n_ridx    = r_ridx + srt_pkg::IDX_W'(1);
                end
            end
            srt_pkg::S_RESP: ;
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srt_pkg::S_IDLE;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
        end
    end

    // Payload and working registers.
    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_key     <= n_key;
        r_data    <= n_data;
        r_ridx    <= n_ridx;
        r_wp      <= n_wp;
        r_removed <= n_removed;
        r_status  <= n_status;
        r_fkey    <= n_fkey;
        r_fdata   <= n_fdata;
    end

    // Record memory with one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // Port outputs.
    assign busy            = (r_state != srt_pkg::S_IDLE);
    assign o_done          = (r_state == srt_pkg::S_RESP);
    assign o_status        = r_status;
    assign o_found_key     = r_fkey;
    assign o_found_data    = r_fdata;
    assign o_removed_count = srt_pkg::OUT_CNT_W'(r_removed);
    assign o_entry_count   = srt_pkg::OUT_CNT_W'(r_fill);

endmodule

`default_nettype wire

>>> design/srt_checker.sv
`default_nettype none

module srt_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                start,
    input wire logic                                busy,
    input wire logic                                o_done,
    input wire logic [1:0]                          o_status,
    input wire logic [srt_pkg::OUT_CNT_W-1:0]       o_removed_count,
    input wire logic [srt_pkg::OUT_CNT_W-1:0]       o_entry_count
);

    // An accepted request keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after an accepted request");

    // A result only appears while the request is still outstanding.
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result shown while idle");

    // A result strobe lasts exactly one cycle and frees the block.
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (!o_done && !busy))
        else $error("result strobe longer than one cycle");

    // A full table refuses the insert and reports its full count.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == srt_pkg::ST_FULL)) |->
        ((o_entry_count == srt_pkg::OUT_CNT_W'(srt_pkg::CAPACITY)) &&
         (o_removed_count == '0)))
        else $error("full status with wrong counts");

    // A failed request removes nothing.
    a_fail_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != srt_pkg::ST_OK)) |-> (o_removed_count == '0))
        else $error("entries removed by a failed request");

endmodule

bind sorted_record_table_top srt_checker u_srt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_done          (o_done),
    .o_status        (o_status),
    .o_removed_count (o_removed_count),
    .o_entry_count   (o_entry_count)
);

`default_nettype wire
